/* sv/ecgs_pkg.sv */
// ============================================================================
// ecgs_pkg
// Shared widths, types and controller codes for the eye-center score block.
// ============================================================================
package ecgs_pkg;

    localparam int COORD_BITS     = 10;
    localparam int GRAD_FRAC_BITS = 14;
    localparam int ACC_BITS       = 50;

    localparam int GRAD_W  = GRAD_FRAC_BITS + 2;      // gradient word
    localparam int DISP_W  = COORD_BITS + 1;          // signed displacement
    localparam int PROD_W  = DISP_W + GRAD_W;         // d * g
    localparam int DOT_W   = PROD_W + 1;              // dx*gx + dy*gy
    localparam int DSQ_W   = 2 * COORD_BITS;          // dx * dx
    localparam int MAG_W   = DSQ_W + 1;               // |d|^2
    localparam int SQ_W    = 2 * (DOT_W - 1);         // dot^2, dot > 0
    localparam int DIV_STEPS = (SQ_W + 1) / 2;        // two quotient bits a cycle
    localparam int DVD_W   = 2 * DIV_STEPS;
    localparam int CNT_W   = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
    localparam int SUM_W   = ((DVD_W > ACC_BITS) ? DVD_W : ACC_BITS) + 1;

    localparam logic [ACC_BITS-1:0] ACC_MAX = {ACC_BITS{1'b1}};

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DOT,
        S_SQUARE,
        S_DIV,
        S_ACC
    } state_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic dot;
        logic square;
        logic div_step;
        logic accum;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic dot_pos;
        logic last;
    } status_t;

endpackage

/* sv/ecgs_if.sv */
// ============================================================================
// ecgs_if
// Valid/ready channels: gradient sample word in, score word out.
// ============================================================================
interface ecgs_sample_if;
    import ecgs_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [COORD_BITS-1:0]    center_x;
    logic [COORD_BITS-1:0]    center_y;
    logic [COORD_BITS-1:0]    point_x;
    logic [COORD_BITS-1:0]    point_y;
    logic signed [GRAD_W-1:0] grad_x;
    logic signed [GRAD_W-1:0] grad_y;
    logic                     last;

    modport source (output valid, center_x, center_y, point_x, point_y,
                    grad_x, grad_y, last, input ready);
    modport sink   (input valid, center_x, center_y, point_x, point_y,
                    grad_x, grad_y, last, output ready);
endinterface

interface ecgs_result_if;
    import ecgs_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACC_BITS-1:0] score;
    logic                overflow;

    modport source (output valid, score, overflow, input ready);
    modport sink   (input valid, score, overflow, output ready);
endinterface

/* sv/ecgs_datapath.sv */
// ============================================================================
// ecgs_datapath
// Displacement, dot product, square, radix-4 restoring divide, saturating sum.
// ============================================================================
module ecgs_datapath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [ecgs_pkg::COORD_BITS-1:0]  center_x,
    input  logic [ecgs_pkg::COORD_BITS-1:0]  center_y,
    input  logic [ecgs_pkg::COORD_BITS-1:0]  point_x,
    input  logic [ecgs_pkg::COORD_BITS-1:0]  point_y,
    input  logic signed [ecgs_pkg::GRAD_W-1:0] grad_x,
    input  logic signed [ecgs_pkg::GRAD_W-1:0] grad_y,
    input  logic                             last,
    input  ecgs_pkg::cmd_t                   cmd,
    output ecgs_pkg::status_t                status,
    output logic [ecgs_pkg::ACC_BITS-1:0]    score,
    output logic                             overflow
);
    import ecgs_pkg::*;

    logic signed [DISP_W-1:0] dx_reg, dy_reg;
    logic signed [GRAD_W-1:0] gx_reg, gy_reg;
    logic                     last_reg;
    logic signed [PROD_W-1:0] pxx_reg, pyy_reg;
    logic [DSQ_W-1:0]         mxx_reg, myy_reg;
    logic signed [DOT_W-1:0]  dot_reg;
    logic [MAG_W-1:0]         mag_reg;
    logic                     dot_pos_reg;
    logic [DVD_W-1:0]         dvd_reg, dvd_next;
    logic [MAG_W-1:0]         rem_reg, rem_next;
    logic [ACC_BITS-1:0]      acc_reg, acc_next;
    logic                     sat_reg, sat_next;
    logic [ACC_BITS-1:0]      score_reg;
    logic                     overflow_reg;

    logic signed [DOT_W-1:0]  dot_sum;
    logic [DOT_W-2:0]         dot_mag;
    logic [SQ_W-1:0]          dot_sq;
    logic [SUM_W-1:0]         sum;
    logic                     sum_ovf;

    assign dot_sum = {pxx_reg[PROD_W-1], pxx_reg} + {pyy_reg[PROD_W-1], pyy_reg};
    assign dot_mag = dot_reg[DOT_W-2:0];
    assign dot_sq  = SQ_W'(dot_mag) * SQ_W'(dot_mag);

    // two restoring steps per cycle; remainder always below mag
    always_comb
    begin
        logic [MAG_W:0]   trial;
        logic [MAG_W-1:0] rem_v;
        logic [DVD_W-1:0] dvd_v;
        rem_v = rem_reg;
        dvd_v = dvd_reg;
        for (int i = 0; i < 2; i++)
        begin
            trial = {rem_v, dvd_v[DVD_W-1]};
            dvd_v = {dvd_v[DVD_W-2:0], 1'b0};
            if (trial >= {1'b0, mag_reg})
            begin
                trial    = trial - {1'b0, mag_reg};
                dvd_v[0] = 1'b1;
            end
            rem_v = trial[MAG_W-1:0];
        end
        rem_next = rem_v;
        dvd_next = dvd_v;
    end

    assign sum     = SUM_W'(acc_reg) + SUM_W'(dvd_reg);
    assign sum_ovf = sum > SUM_W'(ACC_MAX);

    always_comb
    begin
        acc_next = acc_reg;
        sat_next = sat_reg;
        if (dot_pos_reg)
        begin
            acc_next = sum_ovf ? ACC_MAX : sum[ACC_BITS-1:0];
            sat_next = sat_reg | sum_ovf;
        end
    end

    // payload pipeline
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            dx_reg   <= $signed({1'b0, point_x}) - $signed({1'b0, center_x});
            dy_reg   <= $signed({1'b0, point_y}) - $signed({1'b0, center_y});
            gx_reg   <= grad_x;
            gy_reg   <= grad_y;
            last_reg <= last;
        end
        if (cmd.mul)
        begin
            pxx_reg <= PROD_W'(dx_reg) * PROD_W'(gx_reg);
            pyy_reg <= PROD_W'(dy_reg) * PROD_W'(gy_reg);
            mxx_reg <= DSQ_W'(dx_reg) * DSQ_W'(dx_reg);
            myy_reg <= DSQ_W'(dy_reg) * DSQ_W'(dy_reg);
        end
        if (cmd.dot)
        begin
            dot_reg     <= dot_sum;
            mag_reg     <= {1'b0, mxx_reg} + {1'b0, myy_reg};
            dot_pos_reg <= !dot_sum[DOT_W-1] && (dot_sum != '0);
        end
        if (cmd.square)
        begin
            dvd_reg <= DVD_W'(dot_sq);
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
        if (cmd.emit)
        begin
            score_reg    <= acc_next;
            overflow_reg <= sat_next;
        end
    end

    // run state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            sat_reg <= 1'b0;
        end
        else if (cmd.accum)
        begin
            if (cmd.emit)
            begin
                acc_reg <= '0;
                sat_reg <= 1'b0;
            end
            else
            begin
                acc_reg <= acc_next;
                sat_reg <= sat_next;
            end
        end
    end

    assign status.dot_pos = dot_pos_reg;
    assign status.last    = last_reg;
    assign score          = score_reg;
    assign overflow       = overflow_reg;

endmodule

/* sv/ecgs_ctrl.sv */
// ============================================================================
// ecgs_ctrl
// Sequencer for one sample word; owns the result valid flag.
// ============================================================================
module ecgs_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  ecgs_pkg::status_t status,
    output ecgs_pkg::cmd_t    cmd
);
    import ecgs_pkg::*;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_busy;

    assign out_busy = out_valid_reg && !out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_DOT;
            end
            S_DOT:
            begin
                cmd.dot    = 1'b1;
                state_next = S_SQUARE;
            end
            S_SQUARE:
            begin
                cmd.square = 1'b1;
                cnt_next   = '0;
                state_next = status.dot_pos ? S_DIV : S_ACC;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                // a last word waits for the output register to free up
                if (!(status.last && out_busy))
                begin
                    cmd.accum  = 1'b1;
                    cmd.emit   = status.last;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    assign out_valid = out_valid_reg;

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_MUL))
        else $error("accepted word did not start the sequence");

    a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_ACC && status.last))
        else $error("result raised outside a last-word accumulate");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || out_ready))
        else $error("result overwritten before it was taken");

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (cnt_reg <= CNT_W'(DIV_STEPS - 1)))
        else $error("divide step counter out of range");

endmodule

/* sv/eye_center_gradient_score.sv */
// ============================================================================
// eye_center_gradient_score
// Eye-center objective for one candidate center over a stream of gradients.
//
// Each sample word carries a pixel position, its gradient (signed Q1.14) and
// the candidate center. The block forms d = p - c and t = d.g; when t > 0 it
// adds floor(t*t / |d|^2) to a 50-bit accumulator that sticks at all ones and
// sets overflow. Words with t <= 0, d = 0 among them, add nothing. On the word
// flagged last one result word (score in 2^-28 units, overflow) is issued and
// the run state clears. A word steps through capture, multiply, dot sum,
// square, the restoring divider and accumulate; when t <= 0 the divider is
// skipped. The divider retires two quotient bits per cycle over the 54-bit
// square. A new word is taken while the previous result still waits in the
// output register; only a last word that finds that register full holds in
// its accumulate cycle.
// ============================================================================
module eye_center_gradient_score (
    input  logic        clk,
    input  logic        rst_n,
    ecgs_sample_if.sink sample,
    ecgs_result_if.source result
);
    import ecgs_pkg::*;

    cmd_t    cmd;
    status_t status;

    // sequencer: handshakes and command strobes
    ecgs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample.valid),
        .in_ready  (sample.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // arithmetic, run accumulator and result payload
    ecgs_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .center_x (sample.center_x),
        .center_y (sample.center_y),
        .point_x  (sample.point_x),
        .point_y  (sample.point_y),
        .grad_x   (sample.grad_x),
        .grad_y   (sample.grad_y),
        .last     (sample.last),
        .cmd      (cmd),
        .status   (status),
        .score    (result.score),
        .overflow (result.overflow)
    );

endmodule
